>>> hdl/hps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hps_pkg: shared types and constants of the host:port splitter
// Item and result layouts, status and host kind codes, parser limits.
// ----------------------------------------------------------------------------
package hps_pkg;

    localparam int MAX_HOST_LEN = 255;
    localparam int NAME_LIMIT   = (MAX_HOST_LEN < 255) ? MAX_HOST_LEN : 255;

    localparam logic [16:0] PORT_LIMIT   = 17'd65536;
    localparam logic [9:0]  SEG_MAX      = 10'd255;
    localparam logic [1:0]  SEG_DIGITS   = 2'd3;
    localparam logic [2:0]  SEG_LAST_IDX = 3'd3;
    localparam logic [2:0]  SEG_CNT_SAT  = 3'd7;

    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_ADDR = 2'd1;
    localparam logic [1:0] ST_BAD_PORT = 2'd2;

    localparam logic KIND_DOTTED = 1'b0;
    localparam logic KIND_NAME   = 1'b1;

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_end;
    } char_item_t;

    typedef struct packed {
        logic [7:0]  host_length;
        logic [15:0] port_number;
        logic        port_present;
        logic [31:0] ipv4_address;
        logic        host_kind;
        logic [1:0]  status;
    } result_t;

endpackage

>>> hdl/host_port_splitter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// host_port_splitter_top: host[:port] text splitter
// Parses a host[:port] string one byte per request and gives one verdict.
// ----------------------------------------------------------------------------
// Input channel s_*: one byte of text per request in s_tdata; a request with
// s_tlast high ends the string (its byte is ignored) and yields one result.
// Output channel m_*: one result per string: status, address, port and
// host length in m_tdata, host kind (dotted address or name) in m_tuser.
// Each byte passes the input register and the combinational parser logic;
// a terminator then goes on into the result register. Throughput: one
// request per cycle while no terminator waits for the result register.
// When the receiver stalls, the result register holds and byte requests
// keep flowing; only a further terminator waits in the input register
// until the result register frees, which then backs up s_tready.
// Reset clears the parser state and both valid flags; no result is pending.
// ----------------------------------------------------------------------------
module host_port_splitter_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // is_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [1:0] status, [33:2] ipv4_address,
                                   // [34] port_present, [50:35] port_number,
                                   // [58:51] host_length, [63:59] zero
    output logic        m_tuser    // host_kind
);

    hps_pkg::char_item_t s_item;
    hps_pkg::char_item_t item;
    hps_pkg::result_t    res;
    hps_pkg::result_t    m_res;
    logic                item_valid;
    logic                item_take;
    logic                out_free;
    logic                res_valid;

    assign s_item.char_code = s_tdata;
    assign s_item.is_end    = s_tlast;

    hps_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    hps_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .out_free   (out_free),
        .res_valid  (res_valid),
        .res        (res)
    );

    hps_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_res     (m_res)
    );

    assign m_tdata = {5'd0, m_res.host_length, m_res.port_number, m_res.port_present,
                      m_res.ipv4_address, m_res.status};
    assign m_tuser = m_res.host_kind;

    a_fail_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_res.status != hps_pkg::ST_OK) |->
        (m_res.ipv4_address == 32'd0 && m_res.port_number == 16'd0 &&
         m_res.host_length == 8'd0 && !m_res.port_present))
        else $error("failed verdict carries host or port data");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_res.status == hps_pkg::ST_OK ||
                      m_res.status == hps_pkg::ST_BAD_ADDR ||
                      m_res.status == hps_pkg::ST_BAD_PORT))
        else $error("undefined status code");

    a_name_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_res.host_kind == hps_pkg::KIND_NAME) |->
        (m_res.ipv4_address == 32'd0 && m_res.status != hps_pkg::ST_BAD_ADDR))
        else $error("plain name verdict carries address data");

    a_port_absent: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_res.port_present) |-> (m_res.port_number == 16'd0))
        else $error("port number without port");

    a_term_slot: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> out_free)
        else $error("verdict overwrote a pending result");

endmodule

>>> hdl/hps_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hps_in_stage: input register
// Holds one character request until the parser core takes it.
// ----------------------------------------------------------------------------
module hps_in_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_valid,
    output logic                s_ready,
    input  hps_pkg::char_item_t s_item,
    output logic                item_valid,
    output hps_pkg::char_item_t item,
    input  logic                item_take
);

    logic                valid_reg;
    logic                valid_next;
    hps_pkg::char_item_t item_reg;

    assign s_ready    = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_valid && s_ready)
        begin
            valid_next = 1'b1;
        end
        else if (item_take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            item_reg <= s_item;
        end
    end

endmodule

>>> hdl/hps_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hps_core: parser state and verdict logic
// Updates both host readings and the port per character; forms the verdict
// at the terminator and returns all state to reset.
// ----------------------------------------------------------------------------
module hps_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  hps_pkg::char_item_t item,
    output logic                item_take,
    input  logic                out_free,
    output logic                res_valid,
    output hps_pkg::result_t    res
);

    localparam logic [7:0] NAME_MAX = 8'(hps_pkg::NAME_LIMIT);

    logic        after_colon_reg,     after_colon_next;
    logic        saw_dot_reg,         saw_dot_next;
    logic        address_bad_reg,     address_bad_next;
    logic        prev_was_dot_reg,    prev_was_dot_next;
    logic [2:0]  segment_count_reg,   segment_count_next;
    logic [1:0]  segment_digits_reg,  segment_digits_next;
    logic [9:0]  segment_value_reg,   segment_value_next;
    logic [31:0] address_accum_reg,   address_accum_next;
    logic [16:0] port_accum_reg,      port_accum_next;
    logic        port_digit_seen_reg, port_digit_seen_next;
    logic        port_bad_reg,        port_bad_next;
    logic [7:0]  name_length_reg,     name_length_next;

    logic        is_digit;
    logic [3:0]  digit;
    logic [19:0] port_sum;
    logic [9:0]  seg_sum;
    logic        end_bad;
    logic        port_ok;
    logic [31:0] end_addr;

    assign item_take = item_valid && (!item.is_end || out_free);
    assign res_valid = item_take && item.is_end;

    assign is_digit = (item.char_code >= hps_pkg::CHAR_ZERO) &&
                      (item.char_code <= hps_pkg::CHAR_NINE);
    assign digit    = 4'(item.char_code - hps_pkg::CHAR_ZERO);
    assign port_sum = {port_accum_reg, 3'b000} + {2'b00, port_accum_reg, 1'b0}
                      + {16'd0, digit};
    assign seg_sum  = 10'({segment_value_reg, 3'b000} + {segment_value_reg, 1'b0}
                      + {9'd0, digit});

    always_comb
    begin
        after_colon_next     = after_colon_reg;
        saw_dot_next         = saw_dot_reg;
        address_bad_next     = address_bad_reg;
        prev_was_dot_next    = prev_was_dot_reg;
        segment_count_next   = segment_count_reg;
        segment_digits_next  = segment_digits_reg;
        segment_value_next   = segment_value_reg;
        address_accum_next   = address_accum_reg;
        port_accum_next      = port_accum_reg;
        port_digit_seen_next = port_digit_seen_reg;
        port_bad_next        = port_bad_reg;
        name_length_next     = name_length_reg;

        if (item_take && item.is_end)
        begin
            after_colon_next     = 1'b0;
            saw_dot_next         = 1'b0;
            address_bad_next     = 1'b0;
            prev_was_dot_next    = 1'b0;
            segment_count_next   = 3'd0;
            segment_digits_next  = 2'd0;
            segment_value_next   = 10'd0;
            address_accum_next   = 32'd0;
            port_accum_next      = 17'd0;
            port_digit_seen_next = 1'b0;
            port_bad_next        = 1'b0;
            name_length_next     = 8'd0;
        end
        else if (item_take)
        begin
            if (item.char_code == hps_pkg::CHAR_DOT)
            begin
                saw_dot_next = 1'b1;
            end
            if (after_colon_reg)
            begin
                if (is_digit)
                begin
                    if (port_sum > {3'd0, hps_pkg::PORT_LIMIT})
                    begin
                        port_accum_next = hps_pkg::PORT_LIMIT;
                    end
                    else
                    begin
                        port_accum_next = port_sum[16:0];
                    end
                    port_digit_seen_next = 1'b1;
                end
                else
                begin
                    port_bad_next = 1'b1;
                end
            end
            else if (item.char_code == hps_pkg::CHAR_COLON)
            begin
                after_colon_next = 1'b1;
            end
            else
            begin
                if (name_length_reg < NAME_MAX)
                begin
                    name_length_next = name_length_reg + 8'd1;
                end
                if (item.char_code == hps_pkg::CHAR_DOT)
                begin
                    // close the segment in progress
                    if (prev_was_dot_reg || segment_digits_reg == 2'd0 ||
                        segment_value_reg > hps_pkg::SEG_MAX)
                    begin
                        address_bad_next = 1'b1;
                    end
                    address_accum_next = {address_accum_reg[23:0], segment_value_reg[7:0]};
                    if (segment_count_reg < hps_pkg::SEG_CNT_SAT)
                    begin
                        segment_count_next = segment_count_reg + 3'd1;
                    end
                    segment_digits_next = 2'd0;
                    segment_value_next  = 10'd0;
                    prev_was_dot_next   = 1'b1;
                end
                else
                begin
                    prev_was_dot_next = 1'b0;
                    if (is_digit)
                    begin
                        if (segment_digits_reg >= hps_pkg::SEG_DIGITS)
                        begin
                            address_bad_next = 1'b1;
                        end
                        else
                        begin
                            segment_digits_next = segment_digits_reg + 2'd1;
                            segment_value_next  = seg_sum;
                        end
                    end
                    else
                    begin
                        address_bad_next = 1'b1;
                    end
                end
            end
        end
    end

    always_comb
    begin
        end_bad  = address_bad_reg || (segment_digits_reg == 2'd0) ||
                   (segment_value_reg > hps_pkg::SEG_MAX) ||
                   (segment_count_reg != hps_pkg::SEG_LAST_IDX);
        end_addr = {address_accum_reg[23:0], segment_value_reg[7:0]};
        port_ok  = !after_colon_reg ||
                   (!port_bad_reg && port_digit_seen_reg &&
                    (port_accum_reg < hps_pkg::PORT_LIMIT));

        res.host_kind    = saw_dot_reg ? hps_pkg::KIND_DOTTED : hps_pkg::KIND_NAME;
        res.ipv4_address = 32'd0;
        res.port_present = 1'b0;
        res.port_number  = 16'd0;
        res.host_length  = 8'd0;
        if (saw_dot_reg && end_bad)
        begin
            res.status = hps_pkg::ST_BAD_ADDR;
        end
        else if (!port_ok)
        begin
            res.status = hps_pkg::ST_BAD_PORT;
        end
        else
        begin
            res.status       = hps_pkg::ST_OK;
            res.ipv4_address = saw_dot_reg ? end_addr : 32'd0;
            res.port_present = after_colon_reg;
            res.port_number  = after_colon_reg ? port_accum_reg[15:0] : 16'd0;
            res.host_length  = name_length_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            after_colon_reg     <= 1'b0;
            saw_dot_reg         <= 1'b0;
            address_bad_reg     <= 1'b0;
            prev_was_dot_reg    <= 1'b0;
            segment_count_reg   <= 3'd0;
            segment_digits_reg  <= 2'd0;
            segment_value_reg   <= 10'd0;
            address_accum_reg   <= 32'd0;
            port_accum_reg      <= 17'd0;
            port_digit_seen_reg <= 1'b0;
            port_bad_reg        <= 1'b0;
            name_length_reg     <= 8'd0;
        end
        else
        begin
            after_colon_reg     <= after_colon_next;
            saw_dot_reg         <= saw_dot_next;
            address_bad_reg     <= address_bad_next;
            prev_was_dot_reg    <= prev_was_dot_next;
            segment_count_reg   <= segment_count_next;
            segment_digits_reg  <= segment_digits_next;
            segment_value_reg   <= segment_value_next;
            address_accum_reg   <= address_accum_next;
            port_accum_reg      <= port_accum_next;
            port_digit_seen_reg <= port_digit_seen_next;
            port_bad_reg        <= port_bad_next;
            name_length_reg     <= name_length_next;
        end
    end

endmodule

>>> hdl/hps_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hps_out_stage: result register
// Holds one verdict until the receiver takes it.
// ----------------------------------------------------------------------------
module hps_out_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_valid,
    input  hps_pkg::result_t res,
    output logic             out_free,
    output logic             m_valid,
    input  logic             m_ready,
    output hps_pkg::result_t m_res
);

    logic             valid_reg;
    logic             valid_next;
    hps_pkg::result_t res_reg;

    assign out_free = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_res    = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_valid)
        begin
            valid_next = 1'b1;
        end
        else if (m_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule

>>> test/host_port_splitter_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// host_port_splitter_top_test: self-checking bench for the host:port splitter
// Streams host[:port] strings one byte per request with random gaps and
// backpressure, predicts each verdict in a behavioral parser and compares
// every result field against it in order of arrival.
// ----------------------------------------------------------------------------
module host_port_splitter_top_test;

    localparam logic [2:0] SEG_TOTAL    = hps_pkg::SEG_LAST_IDX + 3'd1;
    localparam int         TOTAL_ITEMS  = 1750;
    localparam int         HOLD_CYCLES  = 300;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tuser;

    host_port_splitter_top dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    hps_pkg::char_item_t char_q[$];
    hps_pkg::result_t    verdict_q[$];

    int  sent_cnt   = 0;
    int  hold_left  = 0;
    int  holds_done = 0;
    int  fail_cnt   = 0;
    int  string_cnt = 0;
    int  byte_cnt   = 0;
    int  ok_cnt     = 0;
    int  bad_addr_cnt = 0;
    int  bad_port_cnt = 0;
    logic quiet;

    assign quiet = (sent_cnt >= 700) && (sent_cnt < 1100);

    // parser state of the predictor
    logic        in_port;
    logic        dot_seen;
    logic        addr_bad;
    logic        last_dot;
    logic [2:0]  seg_cnt;
    logic [1:0]  seg_digs;
    logic [9:0]  seg_val;
    logic [31:0] addr_acc;
    logic [16:0] port_acc;
    logic        port_digit;
    logic        port_junk;
    logic [7:0]  name_len;

    function automatic void clear_parse();
        in_port    = 1'b0;
        dot_seen   = 1'b0;
        addr_bad   = 1'b0;
        last_dot   = 1'b0;
        seg_cnt    = '0;
        seg_digs   = '0;
        seg_val    = '0;
        addr_acc   = '0;
        port_acc   = '0;
        port_digit = 1'b0;
        port_junk  = 1'b0;
        name_len   = '0;
    endfunction

    function automatic void close_segment();
        if (last_dot || seg_digs == 2'd0 || seg_val > hps_pkg::SEG_MAX)
            addr_bad = 1'b1;
        addr_acc = {addr_acc[23:0], seg_val[7:0]};
        if (seg_cnt < hps_pkg::SEG_CNT_SAT)
            seg_cnt = seg_cnt + 3'd1;
        seg_digs = '0;
        seg_val  = '0;
    endfunction

    // advance the parser by one request; returns 1 when a verdict is due
    function automatic logic parse_char(input logic [7:0] c, input logic is_end,
                                        output hps_pkg::result_t verdict);
        logic        is_digit;
        logic [31:0] acc;
        logic        port_ok;
        is_digit = (c >= hps_pkg::CHAR_ZERO) && (c <= hps_pkg::CHAR_NINE);
        verdict  = '0;
        if (!is_end)
        begin
            if (c == hps_pkg::CHAR_DOT)
                dot_seen = 1'b1;
            if (in_port)
            begin
                if (is_digit)
                begin
                    acc = port_acc * 10 + (c - hps_pkg::CHAR_ZERO);
                    if (acc > hps_pkg::PORT_LIMIT)
                        acc = 32'(hps_pkg::PORT_LIMIT);
                    port_acc   = acc[16:0];
                    port_digit = 1'b1;
                end
                else
                    port_junk = 1'b1;
            end
            else if (c == hps_pkg::CHAR_COLON)
                in_port = 1'b1;
            else
            begin
                if (name_len < hps_pkg::NAME_LIMIT)
                    name_len = name_len + 8'd1;
                if (c == hps_pkg::CHAR_DOT)
                begin
                    close_segment();
                    last_dot = 1'b1;
                end
                else
                begin
                    last_dot = 1'b0;
                    if (is_digit)
                    begin
                        if (seg_digs >= hps_pkg::SEG_DIGITS)
                            addr_bad = 1'b1;
                        else
                        begin
                            seg_digs = seg_digs + 2'd1;
                            seg_val  = 10'(seg_val * 10 + (c - hps_pkg::CHAR_ZERO));
                        end
                    end
                    else
                        addr_bad = 1'b1;
                end
            end
            return 1'b0;
        end
        verdict.status    = hps_pkg::ST_OK;
        verdict.host_kind = dot_seen ? hps_pkg::KIND_DOTTED : hps_pkg::KIND_NAME;
        if (dot_seen)
        begin
            last_dot = 1'b0;
            if (seg_digs == 2'd0)
                addr_bad = 1'b1;
            close_segment();
            if (seg_cnt != SEG_TOTAL)
                addr_bad = 1'b1;
            if (addr_bad)
                verdict.status = hps_pkg::ST_BAD_ADDR;
        end
        port_ok = !in_port ||
                  (!port_junk && port_digit && port_acc < hps_pkg::PORT_LIMIT);
        if (verdict.status == hps_pkg::ST_OK && !port_ok)
            verdict.status = hps_pkg::ST_BAD_PORT;
        if (verdict.status == hps_pkg::ST_OK)
        begin
            verdict.ipv4_address = dot_seen ? addr_acc : 32'd0;
            verdict.port_present = in_port;
            verdict.port_number  = in_port ? port_acc[15:0] : 16'd0;
            verdict.host_length  = name_len;
        end
        clear_parse();
        return 1'b1;
    endfunction

    // stimulus builders
    task automatic add_item(input logic [7:0] c, input logic is_end);
        hps_pkg::char_item_t item;
        item.char_code = c;
        item.is_end    = is_end;
        char_q.push_back(item);
        byte_cnt++;
        if (is_end)
            string_cnt++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_item(s[i], 1'b0);
    endtask

    task automatic add_end();
        add_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic add_line(input string s);
        add_text(s);
        add_end();
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (c == hps_pkg::CHAR_DOT || c == hps_pkg::CHAR_COLON)
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    task automatic add_segment();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            add_text($sformatf("%0d", $urandom_range(0, 255)));
        else if (pick < 78)
            add_text($sformatf("%03d", $urandom_range(0, 99)));
        else if (pick < 84)
            add_text($sformatf("%0d", $urandom_range(256, 999)));
        else if (pick < 89)
            add_text($sformatf("%0d", $urandom_range(1000, 99999)));
        else if (pick < 95)
            add_item(plain_byte(), 1'b0);
    endtask

    task automatic add_port();
        int pick;
        int run;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return;
        add_item(hps_pkg::CHAR_COLON, 1'b0);
        if (pick < 70)
            add_text($sformatf("%0d", $urandom_range(0, 65535)));
        else if (pick < 78)
            add_text($sformatf("%0d", $urandom_range(65536, 99999)));
        else if (pick < 83)
        begin
            run = $urandom_range(6, 9);
            for (int i = 0; i < run; i++)
                add_item(hps_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)), 1'b0);
        end
        else if (pick < 88)
        begin
        end
        else if (pick < 94)
        begin
            add_text($sformatf("%0d", $urandom_range(0, 999)));
            add_item(plain_byte(), 1'b0);
            add_text($sformatf("%0d", $urandom_range(0, 99)));
        end
        else
        begin
            add_text($sformatf("%0d", $urandom_range(0, 999)));
            add_item(hps_pkg::CHAR_COLON, 1'b0);
            add_text($sformatf("%0d", $urandom_range(0, 99)));
        end
    endtask

    task automatic add_random_string();
        int    pick;
        int    n;
        string mix;
        mix  = "0123456789.:a";
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            n = ($urandom_range(0, 99) < 85) ? 4 : $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
            begin
                if (i > 0)
                    add_item(hps_pkg::CHAR_DOT, 1'b0);
                add_segment();
            end
            add_port();
        end
        else if (pick < 70)
        begin
            n = $urandom_range(0, 16);
            for (int i = 0; i < n; i++)
                add_item(plain_byte(), 1'b0);
            add_port();
        end
        else if (pick < 85)
        begin
            n = $urandom_range(1, 20);
            for (int i = 0; i < n; i++)
                add_item(mix[$urandom_range(0, mix.len() - 1)], 1'b0);
        end
        else if (pick < 99)
        begin
            n = $urandom_range(0, 12);
            for (int i = 0; i < n; i++)
                add_item(8'($urandom_range(0, 255)), 1'b0);
        end
        else
        begin
            n = $urandom_range(240, 300);
            for (int i = 0; i < n; i++)
                add_item(plain_byte(), 1'b0);
            add_port();
        end
        add_end();
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin : drive
        hps_pkg::result_t    verdict;
        hps_pkg::char_item_t nxt_char;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tlast  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                if (parse_char(s_tdata, s_tlast, verdict))
                    verdict_q.push_back(verdict);
                sent_cnt <= sent_cnt + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (char_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 7))
                begin
                    nxt_char = char_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt_char.char_code;
                    s_tlast  <= nxt_char.is_end;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-offs while the sender keeps going
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            holds_done <= 0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if ((holds_done == 0 && sent_cnt >= 300) ||
                 (holds_done == 1 && sent_cnt >= 1500))
        begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_cnt++;
        end
    endtask

    task automatic check_verdict();
        hps_pkg::result_t want;
        if (verdict_q.size() == 0)
        begin
            $error("result with no terminator request pending");
            fail_cnt++;
            return;
        end
        want = verdict_q.pop_front();
        case (want.status)
            hps_pkg::ST_OK:       ok_cnt++;
            hps_pkg::ST_BAD_ADDR: bad_addr_cnt++;
            default:              bad_port_cnt++;
        endcase
        check_field("status",       32'(want.status),       32'(m_tdata[1:0]));
        check_field("host_kind",    32'(want.host_kind),    32'(m_tuser));
        check_field("ipv4_address", want.ipv4_address,      m_tdata[33:2]);
        check_field("port_present", 32'(want.port_present), 32'(m_tdata[34]));
        check_field("port_number",  32'(want.port_number),  32'(m_tdata[50:35]));
        check_field("host_length",  32'(want.host_length),  32'(m_tdata[58:51]));
        check_field("padding",      32'd0,                  32'(m_tdata[63:59]));
    endtask

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
                check_verdict();
            m_tready <= (hold_left == 0) && (quiet || $urandom_range(0, 99) >= 7);
        end
    end

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $error("timeout with %0d requests and %0d results outstanding",
               char_q.size(), verdict_q.size());
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        clear_parse();

        add_line("192.168.1.1:8080");
        add_line("255.255.255.255:65535");
        add_line("0.0.0.0");
        add_line("010.001.1.99:0");
        add_line(".1.2.3");
        add_line("1..2.3");
        add_line("1.2.3.");
        add_line("1234.1.1.1");
        add_line("256.1.1.1");
        add_line("1.2.3");
        add_line("1.2.3.4.5");
        add_line("example.com");
        add_line("localhost:443");
        add_line("host:");
        add_line("host:80:1");
        add_line("1.2.x.4:99999");
        add_line("host:65536");
        add_line("host:99999999");
        add_line("srv:1.5");
        add_line(":80");
        add_line("");
        add_item(8'h00, 1'b0);
        add_line("ab");
        for (int i = 0; i < 300; i++)
            add_item(8'(8'hFF - (i % 2)), 1'b0);
        add_line(":7");

        while (byte_cnt < TOTAL_ITEMS)
            add_random_string();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (char_q.size() != 0 || s_tvalid || verdict_q.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display("Sent %0d strings in %0d byte requests, two long output stalls",
                 string_cnt, byte_cnt);
        $display("Verdicts checked: %0d ok, %0d bad address, %0d bad port",
                 ok_cnt, bad_addr_cnt, bad_port_cnt);
        if (fail_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
